// ===== rtl/qspe_pkg.sv =====
// Package for the queue shortest-path engine: sizes, CSR indices, payload structs.
// Used by queue_shortest_path_engine and the testbench; depends on nothing.
`default_nettype none
package qspe_pkg;
   localparam int NodeCount  = 1024;
   localparam int EdgeSlots  = 8192;
   localparam int WeightBits = 16;
   localparam int NodeBits   = $clog2(NodeCount);
   localparam int SlotBits   = $clog2(EdgeSlots);
   localparam int LinkBits   = SlotBits + 1;
   localparam int CountBits  = SlotBits + 1;
   localparam int EdgeBits   = NodeBits + LinkBits + WeightBits;
   localparam int DistBits   = 32;
   localparam logic [DistBits-1:0] DistNone = '1;

   localparam logic [0:0] CsrSource = 1'b0;
   localparam logic [0:0] CsrTarget = 1'b1;

   typedef struct packed {
      logic [9:0]  node_a;
      logic [9:0]  node_b;
      logic [15:0] edge_weight;
      logic        last_edge;
   } req_type;

   typedef struct packed {
      logic [31:0] target_distance;
      logic        reachable;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [NodeBits-1:0]   to;
      logic [LinkBits-1:0]   link;
      logic [WeightBits-1:0] weight;
   } edge_type;
endpackage
`default_nettype wire

// ===== rtl/qspe_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
`default_nettype none
module qspe_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // A read of the address being written returns the old data; read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/queue_shortest_path_engine.sv =====
// Top level of the queue shortest-path engine: edge loading, SPFA search, answer.
// Depends on qspe_pkg and qspe_ram.
//
//  channel | dir | payload             | handshake
//  req_    | in  | qspe_pkg::req_type  | req_valid / req_ready
//  rsp_    | out | qspe_pkg::rsp_type  | rsp_valid / rsp_ready
//  csr_    | in  | index + 10-bit data | csr_valid / csr_ready
//
// An edge request is accepted, then each of its two arcs is written; a dropped one writes none.
// A last edge then runs an init sweep over all distances and marks,
// then the search: a seed step, a pop and head read per dequeued node, an edge read
// and relax per edge visited plus an enqueue per node queued, the answer read, then a clear.
// After reset the list heads are cleared by a pass over all nodes before any request.
// The response register holds while rsp_ready is low; no request is taken meanwhile.
`default_nettype none
module queue_shortest_path_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  qspe_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output qspe_pkg::rsp_type   rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire                 csr_index,
   input  wire [9:0]           csr_data
);
   localparam int NB = qspe_pkg::NodeBits;
   localparam int SB = qspe_pkg::SlotBits;
   localparam int LB = qspe_pkg::LinkBits;
   localparam int CB = qspe_pkg::CountBits;
   localparam int DB = qspe_pkg::DistBits;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ARC2, S_INIT, S_SEED, S_POP, S_POPW, S_HEAD,
      S_EREAD, S_EWAIT, S_DREAD, S_RELAX, S_UNMARK, S_ANSW, S_ANSR, S_RESP
   } state_type;

   state_type state_ff;
   logic [NB-1:0] src_ff, tgt_ff, sweep_ff;
   logic [CB-1:0] count_ff;
   logic          ovf_ff;
   logic [NB-1:0] a_ff, b_ff;
   logic [qspe_pkg::WeightBits-1:0] w_ff;
   logic          last_ff;
   logic [NB-1:0] qhead_ff, qtail_ff;
   logic [NB:0]   qcnt_ff;
   logic [NB-1:0] k_ff;
   logic [DB-1:0] dk_ff;
   logic [LB-1:0] e_ff;
   qspe_pkg::edge_type ed_ff;
   qspe_pkg::rsp_type  rsp_ff;

   // Memory ports.
   logic          hd_we; logic [NB-1:0] hd_wa, hd_ra; logic [LB-1:0] hd_wd, hd_rd;
   logic          es_we; logic [SB-1:0] es_wa, es_ra;
   qspe_pkg::edge_type es_wd, es_rd;
   logic          ds_we; logic [NB-1:0] ds_wa, ds_ra; logic [DB-1:0] ds_wd, ds_rd;
   logic          mk_we; logic [NB-1:0] mk_wa, mk_ra; logic [0:0] mk_wd, mk_rd;
   logic          wq_we; logic [NB-1:0] wq_wa, wq_ra; logic [NB-1:0] wq_rd;

   qspe_ram #(.Width(LB), .Depth(qspe_pkg::NodeCount)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
   qspe_ram #(.Width(qspe_pkg::EdgeBits), .Depth(qspe_pkg::EdgeSlots)) u_edge (
      .clock, .wr_en(es_we), .wr_addr(es_wa), .wr_data(es_wd), .rd_addr(es_ra), .rd_data(es_rd));
   qspe_ram #(.Width(DB), .Depth(qspe_pkg::NodeCount)) u_dist (
      .clock, .wr_en(ds_we), .wr_addr(ds_wa), .wr_data(ds_wd), .rd_addr(ds_ra), .rd_data(ds_rd));
   qspe_ram #(.Width(1), .Depth(qspe_pkg::NodeCount)) u_mark (
      .clock, .wr_en(mk_we), .wr_addr(mk_wa), .wr_data(mk_wd), .rd_addr(mk_ra), .rd_data(mk_rd));
   qspe_ram #(.Width(NB), .Depth(qspe_pkg::NodeCount)) u_queue (
      .clock, .wr_en(wq_we), .wr_addr(wq_wa), .wr_data(k_ff), .rd_addr(wq_ra), .rd_data(wq_rd));

   // Saturating path sum from the current node.
   logic [DB:0] sum;
   assign sum = {1'b0, dk_ff} + {{(DB+1-qspe_pkg::WeightBits){1'b0}}, ed_ff.weight};
   logic [DB-1:0] nd_in;
   assign nd_in = sum[DB] ? qspe_pkg::DistNone : sum[DB-1:0];
   logic room;
   assign room = ({1'b0, count_ff} + (CB+1)'(2)) <= (CB+1)'(qspe_pkg::EdgeSlots);
   logic sweep_last;
   assign sweep_last = (sweep_ff == NB'(qspe_pkg::NodeCount - 1));

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Memory port control per state.
   always_comb begin
      hd_we = 1'b0; hd_wa = a_ff; hd_wd = LB'(count_ff) + LB'(1); hd_ra = k_ff;
      es_we = 1'b0; es_wa = count_ff[SB-1:0]; es_ra = SB'(e_ff - LB'(1));
      es_wd = '{to: b_ff, link: hd_rd, weight: w_ff};
      ds_we = 1'b0; ds_wa = sweep_ff; ds_wd = qspe_pkg::DistNone; ds_ra = k_ff;
      mk_we = 1'b0; mk_wa = sweep_ff; mk_wd = 1'b0; mk_ra = ed_ff.to;
      wq_we = 1'b0; wq_wa = qtail_ff; wq_ra = qhead_ff;
      case (state_ff)
         S_CLEAR: begin hd_we = 1'b1; hd_wa = sweep_ff; hd_wd = '0; end
         S_IDLE: hd_ra = req_data.node_a[NB-1:0];
         S_ARC2: begin
            // First arc: head of a was read last cycle.
            if (room || arc2_ff) begin
               es_we = 1'b1; hd_we = 1'b1;
            end
            // A self loop's second arc links to the first, which the head read missed.
            if (arc2_ff && a_ff == b_ff) es_wd.link = LB'(count_ff);
            hd_ra = b_ff;
         end
         S_INIT: begin
            ds_we = 1'b1; mk_we = 1'b1;
         end
         S_SEED: begin
            // The source starts at distance zero and marked.
            if (!enq_ff) begin
               ds_we = 1'b1; ds_wa = k_ff; ds_wd = '0;
               mk_we = 1'b1; mk_wa = k_ff; mk_wd = 1'b1;
            end
         end
         S_HEAD: ds_ra = k_ff;
         S_DREAD: begin ds_ra = es_rd.to; mk_ra = es_rd.to; end
         S_RELAX: begin
            if (nd_in < ds_rd) begin
               ds_we = 1'b1; ds_wa = ed_ff.to; ds_wd = nd_in;
               if (!mk_rd[0]) begin mk_we = 1'b1; mk_wa = ed_ff.to; mk_wd = 1'b1; end
            end
         end
         S_UNMARK: begin mk_we = 1'b1; mk_wa = k_ff; mk_wd = 1'b0; end
         S_ANSW: ds_ra = tgt_ff;
         default: ;
      endcase
      // Queue write for newly marked node (k_ff holds it only in seed path).
      if (state_ff == S_SEED) wq_we = 1'b1;
   end

   // Second arc write happens in a dedicated cycle after b's head is read.
   logic arc2_ff;
   logic enq_ff;
   logic [NB-1:0] enq_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; sweep_ff <= '0; count_ff <= '0; ovf_ff <= 1'b0;
         src_ff <= '0; tgt_ff <= NB'(1); arc2_ff <= 1'b0; enq_ff <= 1'b0;
         qcnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               qspe_pkg::CsrSource: src_ff <= csr_data[NB-1:0];
               qspe_pkg::CsrTarget: tgt_ff <= csr_data[NB-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               sweep_ff <= sweep_ff + NB'(1);
               if (sweep_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  a_ff <= req_data.node_a[NB-1:0]; b_ff <= req_data.node_b[NB-1:0];
                  w_ff <= req_data.edge_weight[qspe_pkg::WeightBits-1:0];
                  last_ff <= req_data.last_edge; arc2_ff <= 1'b0;
                  state_ff <= S_ARC2;
               end
            end
            S_ARC2: begin
               if (!arc2_ff) begin
                  if (room) begin
                     count_ff <= count_ff + CB'(1);
                     // Swap endpoints for the reverse arc.
                     a_ff <= b_ff; b_ff <= a_ff; arc2_ff <= 1'b1;
                  end else begin
                     ovf_ff <= 1'b1; arc2_ff <= 1'b0;
                     state_ff <= last_ff ? S_INIT : S_IDLE; sweep_ff <= '0;
                  end
               end else begin
                  count_ff <= count_ff + CB'(1); arc2_ff <= 1'b0;
                  state_ff <= last_ff ? S_INIT : S_IDLE; sweep_ff <= '0;
               end
            end
            S_INIT: begin
               sweep_ff <= sweep_ff + NB'(1);
               if (sweep_last) begin
                  k_ff <= src_ff; state_ff <= S_SEED;
                  qhead_ff <= '0; qtail_ff <= '0; qcnt_ff <= '0;
               end
            end
            S_SEED: begin
               // Enqueue k_ff.
               qtail_ff <= qtail_ff + NB'(1);
               qcnt_ff <= qcnt_ff + (NB+1)'(1);
               state_ff <= (enq_ff) ? S_EREAD : S_POP;
               enq_ff <= 1'b0;
               if (enq_ff) k_ff <= enq_node_ff;
            end
            S_POP: begin
               if (qcnt_ff == '0) state_ff <= S_ANSW;
               else state_ff <= S_POPW;
            end
            S_POPW: begin
               qhead_ff <= qhead_ff + NB'(1);
               qcnt_ff <= qcnt_ff - (NB+1)'(1);
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               k_ff <= wq_rd; state_ff <= S_EWAIT; enq_node_ff <= wq_rd;
               e_ff <= '0; arc2_ff <= 1'b1;
            end
            S_EWAIT: begin
               if (arc2_ff) begin
                  // Head and distance of k arrive next cycle.
                  arc2_ff <= 1'b0;
               end else begin
                  dk_ff <= ds_rd; e_ff <= hd_rd; state_ff <= S_EREAD;
               end
            end
            S_EREAD: begin
               if (e_ff == '0) state_ff <= S_UNMARK;
               else state_ff <= S_DREAD;
               k_ff <= enq_node_ff;
            end
            S_DREAD: begin
               ed_ff <= es_rd; state_ff <= S_RELAX;
            end
            S_RELAX: begin
               e_ff <= ed_ff.link;
               if (nd_in < ds_rd && !mk_rd[0]) begin
                  enq_ff <= 1'b1; k_ff <= ed_ff.to; state_ff <= S_SEED;
               end else state_ff <= S_EREAD;
            end
            S_UNMARK: state_ff <= S_POP;
            S_ANSW: state_ff <= S_ANSR;
            S_ANSR: begin
               rsp_ff.target_distance <= ds_rd;
               rsp_ff.reachable <= (ds_rd != qspe_pkg::DistNone);
               rsp_ff.overflowed <= ovf_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_CLEAR; sweep_ff <= '0; count_ff <= '0; ovf_ff <= 1'b0;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   // Assertions.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("request taken while response pending");
   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(qspe_pkg::EdgeSlots)) else $error("edge count over capacity");
   a_queue_ok: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= (NB+1)'(qspe_pkg::NodeCount) || state_ff == S_IDLE)
      else $error("work queue overfilled");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for queue_shortest_path_engine: loads random weighted graphs,
// predicts each search answer with a scoreboard class, and checks every response.
// Depends on qspe_pkg and the engine RTL.
`default_nettype none
module tb;
   import qspe_pkg::*;

   // Scoreboard: shadow graph store, shortest-path predictor, expected answers.
   class path_scoreboard;
      logic [LinkBits-1:0] head_link[NodeCount];
      edge_type arcs[EdgeSlots];
      int unsigned arc_count;
      bit dropped;
      logic [9:0] src_node, tgt_node;
      rsp_type answers[$];
      int unsigned errors;

      function new();
         foreach (head_link[i]) head_link[i] = '0;
         arc_count = 0;
         dropped = 0;
         src_node = 10'd0;
         tgt_node = 10'd1;
         errors = 0;
      endfunction

      function void set_register(logic [0:0] idx, logic [9:0] value);
         if (idx == CsrSource) src_node = value;
         else tgt_node = value;
      endfunction

      function void add_arc(logic [9:0] from, logic [9:0] to, logic [15:0] w);
         arcs[arc_count].to = to;
         arcs[arc_count].link = head_link[from];
         arcs[arc_count].weight = w;
         arc_count++;
         head_link[from] = LinkBits'(arc_count);
      endfunction

      // Queue-based relaxation from the source; returns the target distance.
      function logic [31:0] shortest_distance();
         logic [31:0] best[NodeCount];
         bit queued[NodeCount];
         int unsigned fifo[$];
         int unsigned k, e, v;
         logic [32:0] sum;
         logic [31:0] nd;
         foreach (best[i]) begin
            best[i] = DistNone;
            queued[i] = 0;
         end
         best[src_node] = '0;
         queued[src_node] = 1;
         fifo.push_back(src_node);
         while (fifo.size() != 0) begin
            k = fifo.pop_front();
            e = head_link[k];
            while (e != 0) begin
               v = arcs[e-1].to;
               sum = {1'b0, best[k]} + 33'(arcs[e-1].weight);
               nd = sum[32] ? DistNone : sum[31:0];
               if (nd < best[v]) begin
                  best[v] = nd;
                  if (!queued[v]) begin
                     queued[v] = 1;
                     fifo.push_back(v);
                  end
               end
               e = arcs[e-1].link;
            end
            queued[k] = 0;
         end
         return best[tgt_node];
      endfunction

      // An accepted edge request; a last edge also yields one expected answer.
      function void note_request(req_type r);
         rsp_type ans;
         if (arc_count + 2 <= EdgeSlots) begin
            add_arc(r.node_a, r.node_b, r.edge_weight);
            add_arc(r.node_b, r.node_a, r.edge_weight);
         end else begin
            dropped = 1;
         end
         if (r.last_edge) begin
            ans.target_distance = shortest_distance();
            ans.reachable = (ans.target_distance != DistNone);
            ans.overflowed = dropped;
            answers.push_back(ans);
            foreach (head_link[i]) head_link[i] = '0;
            arc_count = 0;
            dropped = 0;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp_ans;
         if (answers.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp_ans = answers.pop_front();
         if (got.target_distance !== exp_ans.target_distance) begin
            $display("%0t: target_distance expected %h actual %h", $time,
                     exp_ans.target_distance, got.target_distance);
            errors++;
         end
         if (got.reachable !== exp_ans.reachable) begin
            $display("%0t: reachable expected %b actual %b", $time,
                     exp_ans.reachable, got.reachable);
            errors++;
         end
         if (got.overflowed !== exp_ans.overflowed) begin
            $display("%0t: overflowed expected %b actual %b", $time,
                     exp_ans.overflowed, got.overflowed);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = CsrSource;
   logic [9:0] csr_data = '0;

   path_scoreboard board = new();
   int unsigned idle_pct = 17;
   int unsigned cycles = 0;

   queue_shortest_path_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Run limit, far above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response side: check accepted answers and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   task automatic send_edge(logic [9:0] a, logic [9:0] b, logic [15:0] w, bit last);
      req_type r;
      r.node_a = a;
      r.node_b = b;
      r.edge_weight = w;
      r.last_edge = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
   endtask

   // Drain outstanding answers and let the clear sweep finish.
   task automatic wait_quiet();
      req_valid <= 0;
      @(posedge clock);
      while (board.answers.size() != 0) @(posedge clock);
      repeat (NodeCount + 100) @(posedge clock);
   endtask

   task automatic write_register(logic [0:0] idx, logic [9:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_register(idx, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned g, n, base, span;
      logic [15:0] w;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset registers, extremes, self loop, unreachable target.
      send_edge(10'd0, 10'd1, 16'hFFFF, 1);
      send_edge(10'd1023, 10'd0, 16'h0000, 0);
      send_edge(10'd5, 10'd5, 16'h0007, 0);
      send_edge(10'd2, 10'd3, 16'h0001, 1);
      send_edge(10'd0, 10'd2, 16'd10, 0);
      send_edge(10'd2, 10'd1, 16'd10, 0);
      send_edge(10'd0, 10'd1, 16'd30, 0);
      send_edge(10'd1, 10'd1023, 16'd0, 1);
      wait_quiet();
      // Source equals target, both at the top node.
      write_register(CsrSource, 10'd1023);
      write_register(CsrTarget, 10'd1023);
      send_edge(10'd1023, 10'd512, 16'hFFFF, 1);
      wait_quiet();
      write_register(CsrTarget, 10'd0);
      send_edge(10'd1023, 10'd341, 16'hFFFF, 0);
      send_edge(10'd341, 10'd682, 16'hFFFF, 0);
      send_edge(10'd682, 10'd0, 16'hFFFF, 1);

      // Random graphs, mostly within a small window so paths exist.
      n = 0;
      g = 0;
      while (n < 930) begin
         idle_pct = (g >= 20 && g < 32) ? 0 : 17;
         span = ($urandom_range(3) == 0) ? 1024 : 16;
         base = (span == 1024) ? 0 : $urandom_range(1008);
         if ($urandom_range(1) == 0) begin
            wait_quiet();
            write_register(CsrSource, 10'(base + $urandom_range(span - 1)));
            write_register(CsrTarget, 10'(base + $urandom_range(span - 1)));
         end
         repeat ($urandom_range(1, 24)) begin
            w = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(20));
            send_edge(10'(base + $urandom_range(span - 1)),
                      10'(base + $urandom_range(span - 1)), w, 0);
            n++;
         end
         w = 16'($urandom_range(100));
         send_edge(10'(base + $urandom_range(span - 1)),
                   10'(base + $urandom_range(span - 1)), w, 1);
         n++;
         g++;
      end

      idle_pct = 17;
      wait_quiet();
      if (board.errors == 0 && board.answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
